/* design/asp_pkg.sv */
package asp_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] KIND_PATH_BYTE   = 3'd0;
    localparam logic [2:0] KIND_DATE_BYTE   = 3'd1;
    localparam logic [2:0] KIND_DIRECTORY   = 3'd2;
    localparam logic [2:0] KIND_FILE_HEADER = 3'd3;
    localparam logic [2:0] KIND_FILE_DATA   = 3'd4;
    localparam logic [2:0] KIND_FILE_END    = 3'd5;
    localparam logic [2:0] KIND_ARCHIVE_END = 3'd6;
    localparam logic [2:0] KIND_ERROR       = 3'd7;

    // Error codes reported with the error kind.
    localparam logic [1:0] ERR_BAD_MARKER = 2'd0;
    localparam logic [1:0] ERR_DIR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_AFTER_END  = 2'd2;

    // Characters recognized in the archive stream.
    localparam logic [7:0] CHR_UTF8      = 8'h32;
    localparam logic [7:0] CHR_WIDE      = 8'h31;
    localparam logic [7:0] CHR_NARROW    = 8'h5F;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_SLASH     = 8'h2F;

    // Result queue sizing; a byte produces at most two results.
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_TDATA_W  = 80;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [63:0] file_length;
        logic        path_is_utf8;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

    // Results produced by one parsed byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* design/archive_stream_parser.sv */
// Channel     Direction  tdata                                     tuser  tlast
// s_axis      in         [7:0] data_byte                           -      -
// m_axis      out        [7:0] byte_value, [71:8] file_length,     kind   last
//                        [72] path_is_utf8, [74:73] error_code
//
// One byte is taken per cycle while the result queue has room: a byte is
// registered, then parsed, and its zero, one or two results are written into a
// four-entry result queue. The first result of an accepted byte passes the byte
// register and the result queue before it is valid on m_axis.
// The input stage stalls only while the queue lacks room for two results, so
// the sustained rate is one byte per cycle while results are taken as they come.
// Synchronous active-low reset returns the parser to the start of an entry and
// empties the queue.
module archive_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] byte_value, [71:8] file_length, [72] path_is_utf8, [74:73] error_code
    output logic [asp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast
);

    asp_pkg::t_push   w_push;
    asp_pkg::t_result w_result;
    logic             w_space;

    // Byte register and parser.
    asp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_space (w_space),
        .o_push  (w_push)
    );

    // Result queue feeding the output channel.
    asp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_space  (w_space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    // Output packing.
    assign o_m_axis_tdata = {5'd0, w_result.error_code, w_result.path_is_utf8,
                             w_result.file_length, w_result.byte_value};
    assign o_m_axis_tuser = w_result.kind;
    assign o_m_axis_tlast = w_result.last;

endmodule

/* design/asp_parser.sv */
module asp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_space,
    output asp_pkg::t_push o_push
);

    localparam logic [3:0] PH_ENC   = 4'd0;
    localparam logic [3:0] PH_LMARK = 4'd1;
    localparam logic [3:0] PH_PLEN  = 4'd2;
    localparam logic [3:0] PH_PATH  = 4'd3;
    localparam logic [3:0] PH_DLEN  = 4'd4;
    localparam logic [3:0] PH_DATE  = 4'd5;
    localparam logic [3:0] PH_FLEN  = 4'd6;
    localparam logic [3:0] PH_FILE  = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;
    localparam logic [3:0] PH_ERR   = 4'd9;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [3:0]  r_phase,   n_phase;
    logic        r_utf8,    n_utf8;
    logic        r_wide,    n_wide;
    logic [7:0]  r_flen,    n_flen;
    logic [7:0]  r_fcnt,    n_fcnt;
    logic        r_pslash,  n_pslash;
    logic        r_ppslash, n_ppslash;
    logic [63:0] r_accum,   n_accum;
    logic [63:0] r_remain,  n_remain;

    logic        w_go;
    logic [7:0]  w_b;
    logic [7:0]  w_c;
    logic [7:0]  w_fcnt_inc;
    logic        w_final;
    logic [7:0]  w_need;
    logic [63:0] w_accum_new;
    logic        w_marker_ok;
    logic [1:0]  w_cnt;
    asp_pkg::t_result w_res0;
    asp_pkg::t_result w_res1;

    function automatic asp_pkg::t_result mk(input logic [2:0] kind, input logic [7:0] bv,
                                             input logic [63:0] flen, input logic [1:0] err);
        asp_pkg::t_result r;
        r              = '0;
        r.kind         = kind;
        r.byte_value   = bv;
        r.file_length  = flen;
        r.error_code   = err;
        return r;
    endfunction

    // The input stage is freed whenever its byte is parsed.
    assign w_go    = r_in_valid && i_space;
    assign o_ready = !r_in_valid || i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
        end
    end

    // Shared decode of the current byte.
    assign w_b         = r_in_byte;
    assign w_c         = (w_b == asp_pkg::CHR_BACKSLASH) ? asp_pkg::CHR_SLASH : w_b;
    assign w_fcnt_inc  = r_fcnt + 8'd1;
    assign w_final     = (w_fcnt_inc == r_flen);
    assign w_need      = r_wide ? 8'd8 : 8'd4;
    assign w_marker_ok = (w_b == asp_pkg::CHR_WIDE) || (w_b == asp_pkg::CHR_NARROW);

    // Little-endian length assembly, one byte lane per count value.
    always_comb begin
        w_accum_new = r_accum;
        for (int i = 0; i < 8; i++) begin
            if (r_fcnt[2:0] == 3'(i)) begin
                w_accum_new[8*i +: 8] = r_accum[8*i +: 8] | w_b;
            end
        end
    end

    // Next state and results of one byte.
    always_comb begin
        n_phase   = r_phase;
        n_utf8    = r_utf8;
        n_wide    = r_wide;
        n_flen    = r_flen;
        n_fcnt    = r_fcnt;
        n_pslash  = r_pslash;
        n_ppslash = r_ppslash;
        n_accum   = r_accum;
        n_remain  = r_remain;
        w_cnt     = 2'd0;
        w_res0    = '0;
        w_res1    = '0;
        unique case (r_phase)
            PH_ENC, PH_LMARK: begin
                if (r_phase == PH_ENC && w_b == asp_pkg::CHR_UTF8) begin
                    n_utf8  = 1'b1;
                    n_phase = PH_LMARK;
                end else begin
                    if (r_phase == PH_ENC) begin
                        n_utf8 = 1'b0;
                    end
                    if (w_marker_ok) begin
                        n_wide  = (w_b == asp_pkg::CHR_WIDE);
                        n_phase = PH_PLEN;
                    end else begin
                        n_phase = PH_ERR;
                        n_flen  = {6'd0, asp_pkg::ERR_BAD_MARKER};
                        w_cnt   = 2'd1;
                        w_res0  = mk(asp_pkg::KIND_ERROR, 8'd0, 64'd0, asp_pkg::ERR_BAD_MARKER);
                    end
                end
            end
            PH_PLEN: begin
                if (w_b == 8'd0) begin
                    n_phase = PH_DONE;
                    w_cnt   = 2'd1;
                    w_res0  = mk(asp_pkg::KIND_ARCHIVE_END, 8'd0, 64'd0, 2'd0);
                end else begin
                    n_flen    = w_b;
                    n_fcnt    = 8'd0;
                    n_pslash  = 1'b0;
                    n_ppslash = 1'b0;
                    n_phase   = PH_PATH;
                end
            end
            PH_PATH: begin
                n_fcnt    = w_fcnt_inc;
                n_ppslash = r_pslash;
                // A trailing NUL is dropped and the slash test keeps the byte before it.
                if (w_final && w_c == 8'd0) begin
                    n_pslash = r_pslash;
                end else begin
                    n_pslash = (w_c == asp_pkg::CHR_SLASH);
                    w_cnt    = 2'd1;
                    w_res0   = mk(asp_pkg::KIND_PATH_BYTE, w_c, 64'd0, 2'd0);
                end
                if (w_final) begin
                    n_phase = PH_DLEN;
                end
            end
            PH_DLEN: begin
                n_flen  = w_b;
                n_fcnt  = 8'd0;
                n_accum = 64'd0;
                n_phase = (w_b == 8'd0) ? PH_FLEN : PH_DATE;
            end
            PH_DATE: begin
                w_cnt  = 2'd1;
                w_res0 = mk(asp_pkg::KIND_DATE_BYTE, w_b, 64'd0, 2'd0);
                n_fcnt = w_fcnt_inc;
                if (w_final) begin
                    n_fcnt  = 8'd0;
                    n_accum = 64'd0;
                    n_phase = PH_FLEN;
                end
            end
            PH_FLEN: begin
                n_accum = w_accum_new;
                n_fcnt  = w_fcnt_inc;
                if (w_fcnt_inc >= w_need) begin
                    n_fcnt = 8'd0;
                    if (r_pslash) begin
                        if (w_accum_new != 64'd0) begin
                            n_phase = PH_ERR;
                            n_flen  = {6'd0, asp_pkg::ERR_DIR_LENGTH};
                            w_cnt   = 2'd1;
                            w_res0  = mk(asp_pkg::KIND_ERROR, 8'd0, 64'd0,
                                         asp_pkg::ERR_DIR_LENGTH);
                        end else begin
                            n_phase = PH_ENC;
                            w_cnt   = 2'd1;
                            w_res0  = mk(asp_pkg::KIND_DIRECTORY, 8'd0, 64'd0, 2'd0);
                        end
                    end else begin
                        w_res0 = mk(asp_pkg::KIND_FILE_HEADER, 8'd0, w_accum_new, 2'd0);
                        if (w_accum_new == 64'd0) begin
                            // An empty file ends on the same byte as its header.
                            w_cnt   = 2'd2;
                            w_res1  = mk(asp_pkg::KIND_FILE_END, 8'd0, 64'd0, 2'd0);
                            n_phase = PH_ENC;
                        end else begin
                            w_cnt    = 2'd1;
                            n_remain = w_accum_new;
                            n_phase  = PH_FILE;
                        end
                    end
                end
            end
            PH_FILE: begin
                w_res0   = mk(asp_pkg::KIND_FILE_DATA, w_b, 64'd0, 2'd0);
                n_remain = r_remain - 64'd1;
                if (r_remain == 64'd1) begin
                    w_cnt   = 2'd2;
                    w_res1  = mk(asp_pkg::KIND_FILE_END, 8'd0, 64'd0, 2'd0);
                    n_phase = PH_ENC;
                end else begin
                    w_cnt = 2'd1;
                end
            end
            PH_DONE: begin
                n_phase = PH_ERR;
                n_flen  = {6'd0, asp_pkg::ERR_AFTER_END};
                w_cnt   = 2'd1;
                w_res0  = mk(asp_pkg::KIND_ERROR, 8'd0, 64'd0, asp_pkg::ERR_AFTER_END);
            end
            default: begin
                // Error state and unused codes repeat the stored error.
                w_cnt  = 2'd1;
                w_res0 = mk(asp_pkg::KIND_ERROR, 8'd0, 64'd0, r_flen[1:0]);
            end
        endcase
        w_res0.path_is_utf8 = n_utf8;
        w_res1.path_is_utf8 = n_utf8;
        w_res0.last         = (w_cnt == 2'd1);
        w_res1.last         = (w_cnt == 2'd2);
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ENC;
            r_utf8    <= 1'b0;
            r_wide    <= 1'b0;
            r_flen    <= 8'd0;
            r_fcnt    <= 8'd0;
            r_pslash  <= 1'b0;
            r_ppslash <= 1'b0;
            r_accum   <= 64'd0;
            r_remain  <= 64'd0;
        end else if (w_go) begin
            r_phase   <= n_phase;
            r_utf8    <= n_utf8;
            r_wide    <= n_wide;
            r_flen    <= n_flen;
            r_fcnt    <= n_fcnt;
            r_pslash  <= n_pslash;
            r_ppslash <= n_ppslash;
            r_accum   <= n_accum;
            r_remain  <= n_remain;
        end
    end

    assign o_push.count = w_go ? w_cnt : 2'd0;
    assign o_push.res0  = w_res0;
    assign o_push.res1  = w_res1;

`ifndef SYNTHESIS
    // A file in progress always has data left to come.
    a_file_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FILE) |-> (r_remain != 64'd0))
        else $error("file phase with no data remaining");

    // A pair of results is always data or header followed by a file end.
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_cnt == 2'd2) |->
        ((w_res0.kind == asp_pkg::KIND_FILE_DATA ||
          w_res0.kind == asp_pkg::KIND_FILE_HEADER) &&
         w_res1.kind == asp_pkg::KIND_FILE_END))
        else $error("unexpected result pair");

    // Once in error the parser never leaves it.
    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR) |=> (r_phase == PH_ERR))
        else $error("error state left without reset");
`endif

endmodule

/* design/asp_result_fifo.sv */
module asp_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asp_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output asp_pkg::t_result o_result
);

    asp_pkg::t_result r_mem [asp_pkg::FIFO_DEPTH];

    logic [asp_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [asp_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [asp_pkg::FIFO_CNT_W-1:0] r_count;
    logic [asp_pkg::FIFO_PTR_W-1:0] w_wr_next;
    logic                           w_pop;

    // Room for a full pair is required before the parser takes a byte.
    assign o_space   = (r_count <= asp_pkg::FIFO_CNT_W'(asp_pkg::FIFO_DEPTH - 2));
    assign o_valid   = (r_count != '0);
    assign o_result  = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && i_ready;
    assign w_wr_next = r_wr_ptr + asp_pkg::FIFO_PTR_W'(1);

    // Pointer and fill count tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + asp_pkg::FIFO_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + asp_pkg::FIFO_PTR_W'(w_pop);
            r_count  <= r_count + asp_pkg::FIFO_CNT_W'(i_push.count)
                        - asp_pkg::FIFO_CNT_W'(w_pop);
        end
    end

    // Entry storage; a pair lands in two consecutive slots.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.res1;
        end
    end

`ifndef SYNTHESIS
    // The queue never overfills.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= asp_pkg::FIFO_CNT_W'(asp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");
`endif

endmodule
